// ===== hw/rtl/nfaem_pkg.sv =====
// Package for the epsilon-NFA matcher: operation codes, sequencer states, defaults.
`default_nettype none
package nfaem_pkg;

  localparam int NumStatesDef   = 16;
  localparam int SymbolCountDef = 256;

  localparam int OpW    = 3;
  localparam int StateW = 4;
  localparam int SymW   = 8;
  localparam int ActW   = 16;

  localparam int InDataW  = 24;
  localparam int OutDataW = 24;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 3'd0,
    OP_ADD   = 3'd1,
    OP_MARK  = 3'd2,
    OP_BEGIN = 3'd3,
    OP_FEED  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_CLOSE,
    ST_EMIT
  } seq_state_e;

endpackage
`default_nettype wire

// ===== hw/rtl/nfa_epsilon_matcher.sv =====
// Top level of the epsilon-NFA matcher: item decode, sequencer and output register.
//
// The block holds an NFA of NUM_STATES states over SYMBOL_COUNT byte values and runs
// strings through it one byte per input word. One item is worked on at a time and
// s_axis_tready_o is high only when the sequencer is idle. Add-edge on a byte goes
// through a read-modify-write of the edge RAM (read state, then write state); epsilon
// edges, accepting marks and unknown operations are done in the idle state. Begin
// runs the epsilon closure; feed first reads one edge row per state through the
// single edge RAM read port, then runs the closure. The closure sweeps the states
// one per cycle and repeats the sweep until nothing changes, taking between one and
// NUM_STATES sweeps (typically one or two); a verdict then takes the emit state.
// A clear word, and reset itself, start a clearing pass that writes every edge RAM
// row once, all NUM_STATES * 2**ceil(log2(SYMBOL_COUNT)) rows (4096 by default).
// A verdict word is sent on the master side when end_of_string is set on feed or begin.
`default_nettype none
module nfa_epsilon_matcher #(
  parameter int NUM_STATES   = nfaem_pkg::NumStatesDef,
  parameter int SYMBOL_COUNT = nfaem_pkg::SymbolCountDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // from_state [3:0], to_state [7:4], is_epsilon [8], symbol [16:9], zero [23:17]
  input  wire logic [nfaem_pkg::InDataW-1:0]    s_axis_tdata_i,
  // operation [2:0]
  input  wire logic [nfaem_pkg::OpW-1:0]        s_axis_tuser_i,
  input  wire logic                             s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // accepted [0], active_states [16:1], zero [23:17]
  output logic      [nfaem_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  import nfaem_pkg::*;

  localparam int StW       = $clog2(NUM_STATES);
  localparam int SymIdxW   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int EdgeDepth = NUM_STATES * (2 ** SymIdxW);
  localparam int AddrW     = $clog2(EdgeDepth);

  // input word fields
  logic [StateW-1:0] in_from, in_to;
  logic              in_eps;
  logic [SymW-1:0]   in_sym;
  op_e               in_op;

  assign in_from = s_axis_tdata_i[3:0];
  assign in_to   = s_axis_tdata_i[7:4];
  assign in_eps  = s_axis_tdata_i[8];
  assign in_sym  = s_axis_tdata_i[16:9];
  assign in_op   = op_e'(s_axis_tuser_i);

  logic [StW+StateW-1:0] from_ext, to_ext;
  logic [StW-1:0]        from_idx, to_idx;
  logic                  from_ok, to_ok, sym_ok;

  assign from_ext = {{StW{1'b0}}, in_from};
  assign to_ext   = {{StW{1'b0}}, in_to};
  assign from_idx = from_ext[StW-1:0];
  assign to_idx   = to_ext[StW-1:0];
  assign from_ok  = from_ext < (StW+StateW)'(NUM_STATES);
  assign to_ok    = to_ext < (StW+StateW)'(NUM_STATES);
  assign sym_ok   = {1'b0, in_sym} < (SymW+1)'(SYMBOL_COUNT);

  // sequencer and datapath registers
  seq_state_e state_q, state_d;
  logic [NUM_STATES-1:0] eps_q [NUM_STATES];
  logic [NUM_STATES-1:0] eps_d [NUM_STATES];
  logic [NUM_STATES-1:0] accept_q, accept_d;
  logic [NUM_STATES-1:0] active_q, active_d;
  logic [NUM_STATES-1:0] work_q, work_d;
  logic [StW-1:0]        cnt_q, cnt_d;
  logic [AddrW-1:0]      clr_q, clr_d;
  logic                  changed_q, changed_d;
  logic                  pend_q, pend_d;
  logic [StW-1:0]        from_q, from_d;
  logic [StW-1:0]        to_q, to_d;
  logic [SymIdxW-1:0]    sym_q, sym_d;
  logic                  last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_acc_q, out_acc_d;
  logic [ActW-1:0]       out_act_q, out_act_d;

  logic                  in_fire;
  logic                  cnt_last;
  logic                  emit_go;
  logic [NUM_STATES-1:0] sweep_set;
  logic [NUM_STATES+ActW-1:0] act_ext;

  // edge RAM ports
  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr, ram_raddr;
  logic [NUM_STATES-1:0] ram_wdata, ram_rdata;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_last        = (cnt_q == StW'(NUM_STATES - 1));
  assign emit_go         = !out_valid_q || m_axis_tready_i;
  assign sweep_set       = work_q[cnt_q] ? (work_q | eps_q[cnt_q]) : work_q;
  assign act_ext         = {{ActW{1'b0}}, active_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AddrW'(EdgeDepth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_CLEAR: state_d = ST_CLEAR;
            OP_ADD: begin
              if (from_ok && to_ok && !in_eps && sym_ok) state_d = ST_EDGE_RD;
            end
            OP_BEGIN: state_d = ST_CLOSE;
            OP_FEED:  state_d = sym_ok ? ST_SCAN : ST_CLOSE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_EDGE_RD:   state_d = ST_EDGE_WR;
      ST_EDGE_WR:   state_d = ST_IDLE;
      ST_SCAN: begin
        if (cnt_last) state_d = ST_SCAN_TAIL;
      end
      ST_SCAN_TAIL: state_d = ST_CLOSE;
      ST_CLOSE: begin
        if (cnt_last && !changed_q && (sweep_set == work_q)) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    eps_d       = eps_q;
    accept_d    = accept_q;
    active_d    = active_q;
    work_d      = work_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    changed_d   = changed_q;
    pend_d      = 1'b0;
    from_d      = from_q;
    to_d        = to_q;
    sym_d       = sym_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_acc_d   = out_acc_q;
    out_act_d   = out_act_q;
    ram_we      = 1'b0;
    ram_waddr   = {from_q, sym_q};
    ram_wdata   = ram_rdata | (NUM_STATES'(1) << to_q);
    ram_raddr   = {from_q, sym_q};

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          from_d    = from_idx;
          to_d      = to_idx;
          sym_d     = in_sym[SymIdxW-1:0];
          last_d    = s_axis_tlast_i;
          cnt_d     = '0;
          changed_d = 1'b0;
          case (in_op)
            OP_CLEAR: begin
              for (int i = 0; i < NUM_STATES; i++) begin
                eps_d[i] = '0;
              end
              accept_d = '0;
              active_d = '0;
              clr_d    = '0;
            end
            OP_ADD: begin
              if (from_ok && to_ok && in_eps) begin
                eps_d[from_idx] = eps_q[from_idx] | (NUM_STATES'(1) << to_idx);
              end
            end
            OP_MARK: begin
              if (from_ok) accept_d = accept_q | (NUM_STATES'(1) << from_idx);
            end
            OP_BEGIN: work_d = NUM_STATES'(1);
            OP_FEED:  work_d = '0;
            default:  work_d = work_q;
          endcase
        end
      end
      ST_EDGE_WR: begin
        ram_we = 1'b1;
      end
      ST_SCAN: begin
        // one edge row a cycle; its registered data lands in the next cycle
        ram_raddr = {cnt_q, sym_q};
        pend_d    = active_q[cnt_q];
        if (pend_q) work_d = work_q | ram_rdata;
        cnt_d     = cnt_q + StW'(1);
      end
      ST_SCAN_TAIL: begin
        if (pend_q) work_d = work_q | ram_rdata;
        cnt_d     = '0;
        changed_d = 1'b0;
      end
      ST_CLOSE: begin
        work_d = sweep_set;
        if (cnt_last) begin
          cnt_d     = '0;
          changed_d = 1'b0;
          // a sweep without growth means the set is closed
          if (!changed_q && (sweep_set == work_q)) active_d = work_q;
        end else begin
          cnt_d     = cnt_q + StW'(1);
          changed_d = changed_q || (sweep_set != work_q);
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_acc_d   = |(active_q & accept_q);
          out_act_d   = act_ext[ActW-1:0];
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      for (int i = 0; i < NUM_STATES; i++) begin
        eps_q[i] <= '0;
      end
      accept_q    <= '0;
      active_q    <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      changed_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      eps_q       <= eps_d;
      accept_q    <= accept_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      changed_q   <= changed_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    from_q    <= from_d;
    to_q      <= to_d;
    sym_q     <= sym_d;
    last_q    <= last_d;
    out_acc_q <= out_acc_d;
    out_act_q <= out_act_d;
  end

  nfaem_ram #(
    .WIDTH(NUM_STATES),
    .DEPTH(EdgeDepth)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - ActW - 1){1'b0}}, out_act_q, out_acc_q};

endmodule
`default_nettype wire

// ===== hw/rtl/nfaem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nfaem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== tb/nfaem_checker.sv =====
// Checker for the epsilon-NFA matcher: follows both streams, predicts each verdict, compares.
`timescale 1ns / 1ps
module nfaem_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  // from_state [3:0], to_state [7:4], is_epsilon [8], symbol [16:9], zero [23:17]
  input  logic [nfaem_pkg::InDataW-1:0]  in_data_i,
  // operation [2:0]
  input  logic [nfaem_pkg::OpW-1:0]      in_op_i,
  input  logic                           in_last_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  // accepted [0], active_states [16:1], zero [23:17]
  input  logic [nfaem_pkg::OutDataW-1:0] out_data_i,
  output int                             fails_o,
  output int                             pending_o,
  output int                             words_o,
  output int                             verdicts_o,
  output int                             accepts_o,
  output int                             clears_o
);

  import nfaem_pkg::*;

  localparam int ByteRows = NumStatesDef * SymbolCountDef;

  typedef struct packed {
    logic            accepted;
    logic [ActW-1:0] live;
  } verdict_t;

  logic [ActW-1:0] byte_targets [ByteRows];
  logic [ActW-1:0] eps_targets [NumStatesDef];
  logic [ActW-1:0] acc_states;
  logic [ActW-1:0] live_set;
  verdict_t        verdicts_due [$];

  int fails    = 0;
  int words    = 0;
  int verdicts = 0;
  int accepts  = 0;
  int clears   = 0;

  function automatic void forget_machine();
    for (int i = 0; i < ByteRows; i++) byte_targets[i] = '0;
    for (int i = 0; i < NumStatesDef; i++) eps_targets[i] = '0;
    acc_states = '0;
    live_set   = '0;
  endfunction

  // grow the set along epsilon edges until it stops changing
  function automatic logic [ActW-1:0] eps_reach(input logic [ActW-1:0] seed);
    logic [ActW-1:0] cur;
    logic [ActW-1:0] nxt;
    nxt = seed;
    do begin
      cur = nxt;
      for (int s = 0; s < NumStatesDef; s++) begin
        if (cur[s]) nxt |= eps_targets[s];
      end
    end while (nxt != cur);
    return cur;
  endfunction

  function automatic void queue_verdict();
    verdict_t v;
    v.accepted = |(live_set & acc_states);
    v.live     = live_set;
    verdicts_due = {verdicts_due, v};
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("MISMATCH at %0t: %s expected %h, got %h", $time, what, want, got);
    fails++;
  endtask

  task automatic take_verdict(input logic [OutDataW-1:0] word);
    verdict_t want;
    verdicts++;
    if (word[0]) accepts++;
    if (verdicts_due.size() == 0) begin
      report_mismatch("verdict word with none outstanding", 0, 32'(word));
      return;
    end
    want = verdicts_due.pop_front();
    if (word[0] !== want.accepted)
      report_mismatch("accepted", 32'(want.accepted), 32'(word[0]));
    if (word[ActW:1] !== want.live)
      report_mismatch("active_states", 32'(want.live), 32'(word[ActW:1]));
  endtask

  task automatic take_word(input logic [OpW-1:0] op, input logic [InDataW-1:0] d,
                           input logic last);
    logic [StateW-1:0] src;
    logic [StateW-1:0] dst;
    logic              eps;
    logic [SymW-1:0]   sym;
    logic [ActW-1:0]   reached;
    src     = d[StateW-1:0];
    dst     = d[2*StateW-1:StateW];
    eps     = d[2*StateW];
    sym     = d[2*StateW+SymW:2*StateW+1];
    reached = '0;
    words++;
    case (op)
      OP_CLEAR: begin
        forget_machine();
        clears++;
      end
      OP_ADD: begin
        if (eps) eps_targets[src][dst] = 1'b1;
        else byte_targets[int'(src) * SymbolCountDef + int'(sym)][dst] = 1'b1;
      end
      OP_MARK: acc_states[src] = 1'b1;
      OP_BEGIN: begin
        live_set = eps_reach(ActW'(1));
        if (last) queue_verdict();
      end
      OP_FEED: begin
        for (int s = 0; s < NumStatesDef; s++) begin
          if (live_set[s]) reached |= byte_targets[s * SymbolCountDef + int'(sym)];
        end
        live_set = eps_reach(reached);
        if (last) queue_verdict();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forget_machine();
      verdicts_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) take_verdict(out_data_i);
      if (in_valid_i && in_ready_i) take_word(in_op_i, in_data_i, in_last_i);
    end
    fails_o    <= fails;
    pending_o  <= verdicts_due.size();
    words_o    <= words;
    verdicts_o <= verdicts;
    accepts_o  <= accepts;
    clears_o   <= clears;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the epsilon-NFA matcher: clock, reset, stimulus and final verdict.
`timescale 1ns / 1ps
module tb_top;
  import nfaem_pkg::*;

  localparam logic [OpW-1:0] OpSpareLo = 3'd5;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;
  localparam int LiveWordTarget = 950;
  localparam int PhaseLen       = 320;
  localparam int StallLimit     = 30000;
  localparam int SettleCycles   = 400;

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_data   = '0;
  logic [OpW-1:0]      in_op     = OP_CLEAR;
  logic                in_last   = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_data;

  int src_idle_pct = 30;
  int snk_idle_pct = 81;
  int live_words   = 0;
  int quiet_cycles = 0;
  int fails, pending, words, verdicts, accepts, clears;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  nfa_epsilon_matcher uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .s_axis_tuser_i (in_op),
    .s_axis_tlast_i (in_last),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data)
  );

  nfaem_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .in_op_i    (in_op),
    .in_last_i  (in_last),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .fails_o    (fails),
    .pending_o  (pending),
    .words_o    (words),
    .verdicts_o (verdicts),
    .accepts_o  (accepts),
    .clears_o   (clears)
  );

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [StateW-1:0] pick_state(input int n);
    return StateW'($urandom_range(n - 1));
  endfunction

  function automatic logic [StateW-1:0] rnd_state();
    return StateW'($urandom);
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom);
  endfunction

  function automatic logic [SymW-1:0] rnd_sym();
    return SymW'($urandom);
  endfunction

  task automatic send_word(input logic [OpW-1:0] op, input logic [StateW-1:0] src,
                           input logic [StateW-1:0] dst, input logic eps,
                           input logic [SymW-1:0] sym, input logic last);
    if (live_words < PhaseLen) begin
      src_idle_pct = 30;
      snk_idle_pct <= 81;
    end else if (live_words < 2 * PhaseLen) begin
      src_idle_pct = 81;
      snk_idle_pct <= 30;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct <= 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_data  <= {{(InDataW - SymW - 1 - 2 * StateW){1'b0}}, sym, eps, dst, src};
    in_last  <= last;
    do @(posedge clk_i); while (!in_ready);
    if (op <= OP_FEED) live_words++;
  endtask

  // hold the sender until every outstanding verdict has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // build a random machine over a small alphabet, then run strings through it
  task automatic run_machine();
    logic [SymW-1:0] alpha [4];
    int              n_st;
    int              len;
    for (int i = 0; i < 4; i++) alpha[i] = SymW'($urandom_range(255));
    if ($urandom_range(3) == 0) begin
      alpha[0] = '0;
      alpha[3] = '1;
    end
    n_st = ($urandom_range(7) == 0) ? NumStatesDef : $urandom_range(2, NumStatesDef);
    if ($urandom_range(3) == 0)
      send_word(OP_CLEAR, rnd_state(), rnd_state(), rnd_bit(), rnd_sym(), rnd_bit());
    // epsilon chain running against the state numbering: needs many closure sweeps
    if ($urandom_range(5) == 0) begin
      send_word(OP_ADD, '0, StateW'(n_st - 1), 1'b1, rnd_sym(), rnd_bit());
      for (int k = n_st - 1; k > 1; k--)
        send_word(OP_ADD, StateW'(k), StateW'(k - 1), 1'b1, rnd_sym(), rnd_bit());
    end
    repeat ($urandom_range(2, 2 * n_st)) begin
      send_word(OP_ADD, pick_state(n_st), pick_state(n_st), 1'b0,
                ($urandom_range(15) == 0) ? rnd_sym() : alpha[$urandom_range(3)],
                rnd_bit());
    end
    repeat ($urandom_range(3))
      send_word(OP_ADD, pick_state(n_st), pick_state(n_st), 1'b1, rnd_sym(), rnd_bit());
    repeat ($urandom_range(1, 3))
      send_word(OP_MARK, pick_state(n_st), rnd_state(), rnd_bit(), rnd_sym(), rnd_bit());
    repeat ($urandom_range(2, 6)) begin
      if ($urandom_range(7) == 0)
        send_word(OpW'($urandom_range(OpSpareLo, OpSpareHi)), rnd_state(), rnd_state(),
                  rnd_bit(), rnd_sym(), rnd_bit());
      if ($urandom_range(9) == 0)
        send_word(OP_FEED, rnd_state(), rnd_state(), rnd_bit(), alpha[$urandom_range(3)],
                  rnd_bit());
      len = $urandom_range(7);
      send_word(OP_BEGIN, rnd_state(), rnd_state(), rnd_bit(), rnd_sym(), len == 0);
      for (int i = 1; i <= len; i++) begin
        send_word(OP_FEED, rnd_state(), rnd_state(), rnd_bit(),
                  ($urandom_range(9) == 0) ? rnd_sym() : alpha[$urandom_range(3)],
                  i == len);
      end
    end
    if ($urandom_range(5) == 0) wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // feed before any begin, then the empty string on an empty machine
    send_word(OP_FEED, 4'hF, 4'h0, 1'b1, 8'hFF, 1'b1);
    send_word(OP_BEGIN, 4'h0, 4'hF, 1'b0, 8'h00, 1'b1);
    send_word(OP_MARK, 4'h0, 4'hF, 1'b1, 8'hFF, 1'b0);
    send_word(OP_BEGIN, 4'hF, 4'h0, 1'b1, 8'hFF, 1'b1);
    send_word(OP_MARK, 4'hF, 4'h0, 1'b0, 8'h00, 1'b1);
    send_word(OP_ADD, 4'h0, 4'hF, 1'b0, 8'h00, 1'b0);
    send_word(OP_ADD, 4'hF, 4'h0, 1'b0, 8'hFF, 1'b1);
    send_word(OP_ADD, 4'hF, 4'h7, 1'b1, 8'hA5, 1'b0);
    send_word(OP_ADD, 4'h7, 4'h3, 1'b1, 8'h5A, 1'b1);
    for (int c = OpSpareLo; c <= OpSpareHi; c++)
      send_word(OpW'(c), rnd_state(), rnd_state(), rnd_bit(), rnd_sym(), rnd_bit());
    send_word(OP_BEGIN, 4'h0, 4'h0, 1'b0, 8'h00, 1'b0);
    send_word(OP_FEED, 4'h0, 4'h0, 1'b0, 8'h00, 1'b0);
    send_word(OP_FEED, 4'hF, 4'hF, 1'b1, 8'hFF, 1'b1);
    send_word(OP_BEGIN, 4'h0, 4'h0, 1'b0, 8'h00, 1'b0);
    send_word(OP_FEED, 4'h0, 4'h0, 1'b0, 8'h00, 1'b1);
    // a byte with no edges empties the set; the empty set is kept past the verdict
    send_word(OP_FEED, 4'h0, 4'h0, 1'b0, 8'h5A, 1'b1);
    send_word(OP_FEED, 4'h0, 4'h0, 1'b0, 8'h00, 1'b1);
    send_word(OP_CLEAR, 4'hF, 4'hF, 1'b1, 8'hFF, 1'b1);
    send_word(OP_BEGIN, 4'h0, 4'h0, 1'b0, 8'h00, 1'b1);
    wait_drained();

    while (live_words < LiveWordTarget) run_machine();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Run covered %0d words in, %0d machine clears, %0d verdicts out",
             words, clears, verdicts);
    $display("Verdicts split %0d accept / %0d reject; %0d mismatches",
             accepts, verdicts - accepts, fails);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
